// File: design/tdrq_pkg.sv
// Shared constants, types and helpers of the timer-driven run queue.
`default_nettype none

package tdrq_pkg;

    // Sizing
    localparam int NUM_TASKS   = 16;
    localparam int NUM_TIMERS  = 3;
    localparam int TIMER_WIDTH = 16;

    // Fixed field and register widths
    localparam int FUNC_W      = 2;
    localparam int TASK_W      = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    // Register map always carries three timers
    localparam int MAP_TIMERS  = 3;
    localparam int TMR_IDX_W   = 2;
    localparam logic [TMR_IDX_W-1:0] TMR_LAST = TMR_IDX_W'(NUM_TIMERS - 1);

    // Wake sets only cover the low sixteen tasks
    localparam int WAKE_W      = (NUM_TASKS < 16) ? NUM_TASKS : 16;
    localparam int WAKE_IDX_W  = $clog2(WAKE_W);

    // Run queue storage
    localparam int PTR_W       = $clog2(NUM_TASKS);
    localparam int CNT_W       = $clog2(NUM_TASKS + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // Input operation codes
    localparam logic [FUNC_W-1:0] FUNC_WAKE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER0_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER1_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER2_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER0_LISTENERS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER1_LISTENERS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER2_LISTENERS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LISTENERS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_LISTENERS  = 3'd7;

    // Back-end command kinds
    localparam logic [1:0] CMD_WAKESET = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WAKE_W-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic [MAP_TIMERS-1:0][CFG_W-1:0] interval;
        logic [MAP_TIMERS-1:0][CFG_W-1:0] listeners;
        logic [CFG_W-1:0]                 idle_listeners;
        logic [CFG_W-1:0]                 start_listeners;
    } cfg_t;

    // Index of the lowest set bit; zero for an empty mask
    function automatic logic [WAKE_IDX_W-1:0] lowest_bit(input logic [WAKE_W-1:0] mask);
        logic [WAKE_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WAKE_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = WAKE_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: design/tdrq_front.sv
// Front end: register file and classification of input beats into commands.
`default_nettype none

module tdrq_front import tdrq_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [TASK_W-1:0]    s_task_req,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TIMER0_INTERVAL:  cfg_next.interval[0]     = cfg_wdata;
                REG_TIMER1_INTERVAL:  cfg_next.interval[1]     = cfg_wdata;
                REG_TIMER2_INTERVAL:  cfg_next.interval[2]     = cfg_wdata;
                REG_TIMER0_LISTENERS: cfg_next.listeners[0]    = cfg_wdata;
                REG_TIMER1_LISTENERS: cfg_next.listeners[1]    = cfg_wdata;
                REG_TIMER2_LISTENERS: cfg_next.listeners[2]    = cfg_wdata;
                REG_IDLE_LISTENERS:   cfg_next.idle_listeners  = cfg_wdata;
                REG_START_LISTENERS:  cfg_next.start_listeners = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg     = cfg_reg;
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Single wakes and start become a wake set; out-of-range tasks give an empty set
    always_comb begin
        q_cmd = '0;
        case (s_func)
            FUNC_WAKE: begin
                q_cmd.kind = CMD_WAKESET;
                if (32'(s_task_req) < WAKE_W) begin
                    q_cmd.mask[s_task_req[WAKE_IDX_W-1:0]] = 1'b1;
                end
            end
            FUNC_POP: begin
                q_cmd.kind = CMD_POP;
            end
            FUNC_TICK: begin
                q_cmd.kind = CMD_TICK;
            end
            FUNC_START: begin
                q_cmd.kind = CMD_WAKESET;
                q_cmd.mask = cfg_reg.start_listeners[WAKE_W-1:0];
            end
            default: begin
                q_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/tdrq_cmd_fifo.sv
// Short command queue between front and back end.
`default_nettype none

module tdrq_cmd_fifo import tdrq_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;

    function automatic logic [CMDQ_PTR_W-1:0] wrap(input logic [CMDQ_PTR_W-1:0] p);
        return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/tdrq_back.sv
// Back end: run queue, timers, wake-set walker and result register.
`default_nettype none

module tdrq_back import tdrq_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_t                   cfg,
    input  wire logic                   cmd_valid,
    input  wire cmd_t                   cmd,
    output logic                        cmd_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [TASK_W-1:0]           m_task_id,
    output logic                        m_task_valid,
    output logic [COUNT_OUT_W-1:0]      m_queue_count
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_TIMER = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_TASKS);

    logic [1:0]             state_reg,   state_next;
    logic [WAKE_W-1:0]      mask_reg,    mask_next;
    logic                   tick_reg,    tick_next;
    logic [TMR_IDX_W-1:0]   tmr_idx_reg, tmr_idx_next;
    logic [PTR_W-1:0]       head_reg,    head_next;
    logic [PTR_W-1:0]       tail_reg,    tail_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [WAKE_W-1:0]      flags_reg,   flags_next;
    logic [TIMER_WIDTH-1:0] tcount_reg [MAP_TIMERS];
    logic [TIMER_WIDTH-1:0] tcount_next [MAP_TIMERS];
    logic [TASK_W-1:0]      res_id_reg,  res_id_next;
    logic                   res_tv_reg,  res_tv_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TASK_W-1:0]      out_id_reg,  out_id_next;
    logic                   out_tv_reg,  out_tv_next;
    logic [COUNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    // Run queue storage, no reset: entries are read only after being written
    logic [TASK_W-1:0]      store_reg [NUM_TASKS];
    logic                   store_we;
    logic [TASK_W-1:0]      store_wdata;

    logic [WAKE_IDX_W-1:0]  walk_idx;
    logic [TASK_W-1:0]      head_task;
    logic [TIMER_WIDTH-1:0] tmr_iv;
    logic [TIMER_WIDTH-1:0] tmr_cur;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_TASKS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign walk_idx  = lowest_bit(mask_reg);
    assign head_task = store_reg[head_reg];
    assign tmr_iv    = TIMER_WIDTH'(cfg.interval[tmr_idx_reg]);
    assign tmr_cur   = tcount_reg[tmr_idx_reg];

    always_comb begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        tick_next      = tick_reg;
        tmr_idx_next   = tmr_idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        flags_next     = flags_reg;
        tcount_next    = tcount_reg;
        res_id_next    = res_id_reg;
        res_tv_next    = res_tv_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_tv_next    = out_tv_reg;
        out_cnt_next   = out_cnt_reg;
        cmd_pop        = 1'b0;
        store_we       = 1'b0;
        store_wdata    = TASK_W'(walk_idx);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop     = 1'b1;
                    res_id_next = '0;
                    res_tv_next = 1'b0;
                    tick_next   = 1'b0;
                    case (cmd.kind)
                        CMD_POP: begin
                            if (count_reg != '0) begin
                                res_id_next = head_task;
                                res_tv_next = 1'b1;
                                head_next   = wrap(head_reg);
                                count_next  = count_reg - 1'b1;
                                flags_next[head_task[WAKE_IDX_W-1:0]] = 1'b0;
                                state_next  = ST_DONE;
                            end else begin
                                mask_next  = cfg.idle_listeners[WAKE_W-1:0];
                                state_next = ST_WALK;
                            end
                        end
                        CMD_TICK: begin
                            tick_next    = 1'b1;
                            tmr_idx_next = '0;
                            state_next   = ST_TIMER;
                        end
                        default: begin
                            mask_next  = cmd.mask;
                            state_next = ST_WALK;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (mask_reg == '0) begin
                    if (tick_reg && (tmr_idx_reg != TMR_LAST)) begin
                        tmr_idx_next = tmr_idx_reg + 1'b1;
                        state_next   = ST_TIMER;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    mask_next[walk_idx] = 1'b0;
                    if (!flags_reg[walk_idx] && (count_reg < FULL_COUNT)) begin
                        store_we             = 1'b1;
                        tail_next            = wrap(tail_reg);
                        count_next           = count_reg + 1'b1;
                        flags_next[walk_idx] = 1'b1;
                    end
                end
            end

            ST_TIMER: begin
                if ((tmr_iv != '0) && (tmr_cur == TIMER_WIDTH'(1))) begin
                    tcount_next[tmr_idx_reg] = tmr_iv;
                    mask_next  = cfg.listeners[tmr_idx_reg][WAKE_W-1:0];
                    state_next = ST_WALK;
                end else begin
                    if (tmr_iv != '0) begin
                        tcount_next[tmr_idx_reg] = (tmr_cur == '0) ? tmr_iv
                                                                   : tmr_cur - 1'b1;
                    end
                    if (tmr_idx_reg == TMR_LAST) begin
                        state_next = ST_DONE;
                    end else begin
                        tmr_idx_next = tmr_idx_reg + 1'b1;
                    end
                end
            end

            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_tv_next    = res_tv_reg;
                    out_cnt_next   = COUNT_OUT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[tail_reg] <= store_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        out_id_reg  <= out_id_next;
        out_tv_reg  <= out_tv_next;
        out_cnt_reg <= out_cnt_next;
        res_id_reg  <= res_id_next;
        res_tv_reg  <= res_tv_next;
        mask_reg    <= mask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_reg      <= 1'b0;
            tmr_idx_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAP_TIMERS; k++) begin
                tcount_reg[k] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            tmr_idx_reg   <= tmr_idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            tcount_reg    <= tcount_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_task_id     = out_id_reg;
    assign m_task_valid  = out_tv_reg;
    assign m_queue_count = out_cnt_reg;

endmodule

`default_nettype wire

// File: design/timer_driven_run_queue_unit.sv
// Top level of the timer-driven run queue: front end, command queue, back end.
//
// Usage:
//   Input beats (s_func, s_task_req) arrive on a valid/ready channel; every
//   beat yields exactly one result beat (m_task_id, m_task_valid,
//   m_queue_count) on the m_ channel, in order.
//   Operations: wake one task, pop the queue head (an empty pop wakes the idle
//   listeners), tick the timers, start (wake the start listeners).
//   The user writes registers through cfg_we/cfg_index/cfg_wdata only while
//   no beat is in flight (not enforced); they take effect at the next edge.
// Timing:
//   The front end takes a beat whenever its two-entry command queue has room.
//   The back end executes one command at a time: a pop with a task goes from
//   idle straight to done; a wake set walks its set bits before done; a tick
//   visits each timer in turn and walks the listeners of each expiring one.
//   The wake-set walker appends one task per cycle.
// Reset (aresetn low, synchronous): queue empty, all flags clear, timers and
//   registers at zero, no result pending.
// Back-pressure: the result register holds its beat while m_ready is low; the
//   back end stalls, and once the command queue fills s_ready drops.
`default_nettype none

module timer_driven_run_queue_unit import tdrq_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [FUNC_W-1:0]      s_func,
    input  wire logic [TASK_W-1:0]      s_task_req,
    // Result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [TASK_W-1:0]           m_task_id,
    output logic                        m_task_valid,
    output logic [COUNT_OUT_W-1:0]      m_queue_count,
    // Register write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    // Register file and beat classification
    tdrq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_task_req (s_task_req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .cfg        (cfg)
    );

    // Decouples acceptance from execution
    tdrq_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Queue, timers and result register
    tdrq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_task_id     (m_task_id),
        .m_task_valid  (m_task_valid),
        .m_queue_count (m_queue_count)
    );

    // A result without a popped task carries task zero
    a_no_task_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_task_valid) |-> (m_task_id == '0))
        else $error("result without task carries non-zero task id");

    // A pop always leaves room for at least one task
    a_pop_leaves_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_task_valid) |-> (32'(m_queue_count) < NUM_TASKS))
        else $error("queue count too high after pop");

    // Command queue only pops what it holds
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("command queue popped while empty");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the timer-driven run queue unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdrq_pkg::*;

    localparam int NUM_REGS         = 2 ** CFG_IDX_W;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 64;

    // One result beat as the block presents it
    typedef struct packed {
        logic [TASK_W-1:0]      task_id;
        logic                   task_valid;
        logic [COUNT_OUT_W-1:0] queue_count;
    } sched_beat_t;

    // Clock, reset and block ports; every input starts at a known value
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [FUNC_W-1:0]      s_func        = FUNC_WAKE;
    logic [TASK_W-1:0]      s_task_req    = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [TASK_W-1:0]      m_task_id;
    logic                   m_task_valid;
    logic [COUNT_OUT_W-1:0] m_queue_count;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = REG_TIMER0_INTERVAL;
    logic [CFG_W-1:0]       cfg_wdata     = '0;

    // Run-queue mirror: circular slot store, pointers, fill level and queued flags
    logic [TASK_W-1:0]      rq_slots [NUM_TASKS];
    int unsigned            rq_head = 0;
    int unsigned            rq_tail = 0;
    int unsigned            rq_fill = 0;
    logic [NUM_TASKS-1:0]   rq_flags = '0;
    logic [TIMER_WIDTH-1:0] tmr_left [NUM_TIMERS];
    logic [CFG_W-1:0]       cfg_shadow [NUM_REGS];
    logic [CFG_W-1:0]       staged_regs [NUM_REGS];

    // Beats predicted at input acceptance, oldest first
    sched_beat_t            due_responses [$];
    int unsigned            fault_count = 0;

    // Idling control shared by the sender and the receiver
    bit                     gaps_on = 1'b1;
    int unsigned            holds_wanted = 0;
    int unsigned            holds_done = 0;

    timer_driven_run_queue_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_task_req    (s_task_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_task_id     (m_task_id),
        .m_task_valid  (m_task_valid),
        .m_queue_count (m_queue_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mirror state matches the block straight after reset
    initial begin
        for (int i = 0; i < NUM_TASKS; i++) rq_slots[i] = '0;
        for (int k = 0; k < NUM_TIMERS; k++) tmr_left[k] = '0;
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_shadow[r]  = '0;
            staged_regs[r] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Run-queue prediction
    // ------------------------------------------------------------------

    // Append a task unless it is out of range, already queued or the store is full
    function automatic void enqueue_task(input int unsigned t);
        if (t >= NUM_TASKS) return;
        if (rq_flags[t] || rq_fill >= NUM_TASKS) return;
        rq_slots[rq_tail] = TASK_W'(t);
        rq_tail           = (rq_tail + 1) % NUM_TASKS;
        rq_fill++;
        rq_flags[t]       = 1'b1;
    endfunction

    // Listener sets are walked from task 0 upwards
    function automatic void wake_listeners(input logic [CFG_W-1:0] mask);
        for (int i = 0; i < CFG_W && i < NUM_TASKS; i++)
            if (mask[i]) enqueue_task(i);
    endfunction

    // Advance the mirror by one input beat and return the beat it should produce
    function automatic sched_beat_t apply_sched_op(input logic [FUNC_W-1:0] op,
                                                   input logic [TASK_W-1:0] req);
        sched_beat_t            r;
        logic [TIMER_WIDTH-1:0] iv;
        r = '0;
        case (op)
            FUNC_WAKE: begin
                enqueue_task(req);
            end
            FUNC_POP: begin
                if (rq_fill > 0) begin
                    r.task_id    = rq_slots[rq_head];
                    r.task_valid = 1'b1;
                    rq_head      = (rq_head + 1) % NUM_TASKS;
                    rq_fill--;
                    rq_flags[r.task_id] = 1'b0;
                end else begin
                    // empty pop: idle set gets woken instead
                    wake_listeners(cfg_shadow[REG_IDLE_LISTENERS]);
                end
            end
            FUNC_TICK: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    iv = TIMER_WIDTH'(cfg_shadow[REG_TIMER0_INTERVAL + k]);
                    if (iv != 0) begin
                        if (tmr_left[k] == 0) begin
                            // first tick after enable only loads
                            tmr_left[k] = iv;
                        end else if (tmr_left[k] == 1) begin
                            tmr_left[k] = iv;
                            wake_listeners(cfg_shadow[REG_TIMER0_LISTENERS + k]);
                        end else begin
                            tmr_left[k] = tmr_left[k] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                wake_listeners(cfg_shadow[REG_START_LISTENERS]);
            end
        endcase
        r.queue_count = COUNT_OUT_W'(rq_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic log_fault(input string why, input sched_beat_t want,
                             input sched_beat_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t %s: expected id=%0d valid=%0d count=%0d, got id=%0d valid=%0d count=%0d",
                     $realtime, why, want.task_id, want.task_valid, want.queue_count,
                     got.task_id, got.task_valid, got.queue_count);
    endtask

    // Each accepted result beat is matched against the oldest prediction
    always @(posedge aclk) begin : check_results
        sched_beat_t seen;
        sched_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_task_id, m_task_valid, m_queue_count};
            if (due_responses.size() == 0) begin
                log_fault("result beat with nothing outstanding", '0, seen);
            end else begin
                want = due_responses.pop_front();
                if (seen !== want) log_fault("result mismatch", want, seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus long holds on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int burst;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_wanted) begin
                // long hold-off, counted here cycle by cycle
                holds_done++;
                m_ready <= 1'b0;
                for (int c = 1; c < LONG_HOLD_CYCLES; c++) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register helpers; all called and returning at a falling edge
    // ------------------------------------------------------------------

    // Offer one beat, wait for acceptance, record its prediction.
    // Valid is left high on return; the next caller either reloads or drops it.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [TASK_W-1:0] req);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= op;
        s_task_req <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_responses.push_back(apply_sched_op(op, req));
        @(negedge aclk);
    endtask

    // Stop offering, wait for every outstanding beat, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (due_responses.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all eight registers from staged_regs while the block is idle
    task automatic load_config();
        settle();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we        <= 1'b1;
            cfg_index     <= CFG_IDX_W'(r);
            cfg_wdata     <= staged_regs[r];
            cfg_shadow[r]  = staged_regs[r];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Random traffic with a weighted operation mix (percentages; rest is start)
    task automatic run_mix(input int n, input int wake_pct, input int pop_pct,
                           input int tick_pct);
        int                pick;
        logic [FUNC_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < wake_pct)                           op = FUNC_WAKE;
            else if (pick < wake_pct + pop_pct)            op = FUNC_POP;
            else if (pick < wake_pct + pop_pct + tick_pct) op = FUNC_TICK;
            else                                           op = FUNC_START;
            send_op(op, TASK_W'($urandom_range(0, NUM_TASKS - 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers still at reset: plain wakes, duplicates, pops and empty pops
    task automatic test_basic_queue();
        send_op(FUNC_POP, '0);          // empty pop, no idle listeners
        send_op(FUNC_START, '0);        // empty start set
        send_op(FUNC_TICK, '0);         // all timers disabled
        send_op(FUNC_WAKE, 4'd0);
        send_op(FUNC_WAKE, 4'd15);
        send_op(FUNC_WAKE, 4'd0);       // already queued, ignored
        send_op(FUNC_WAKE, 4'd7);
        repeat (4) send_op(FUNC_POP, '0);
    endtask

    // Start and idle sets, a full queue, timers loading from zero and expiring
    task automatic test_listener_sets();
        staged_regs[REG_TIMER0_INTERVAL]  = 16'd1;
        staged_regs[REG_TIMER1_INTERVAL]  = 16'd3;
        staged_regs[REG_TIMER2_INTERVAL]  = 16'd2;
        staged_regs[REG_TIMER0_LISTENERS] = 16'h0003;
        staged_regs[REG_TIMER1_LISTENERS] = 16'h0C00;
        staged_regs[REG_TIMER2_LISTENERS] = 16'h0100;
        staged_regs[REG_IDLE_LISTENERS]   = 16'hFFFF;
        staged_regs[REG_START_LISTENERS]  = 16'h8421;
        load_config();
        send_op(FUNC_START, '0);
        send_op(FUNC_WAKE, 4'd5);       // queued by the start set already
        repeat (5) send_op(FUNC_POP, '0); // last one finds it empty: all 16 woken
        send_op(FUNC_WAKE, 4'd3);       // queue full
        send_op(FUNC_TICK, '0);         // counts at zero only load
        send_op(FUNC_POP, '0);
        send_op(FUNC_TICK, '0);         // timer 0 at one expires
        send_op(FUNC_POP, '0);
        send_op(FUNC_TICK, '0);
        send_op(FUNC_TICK, '0);
    endtask

    // Short intervals and random listener sets under balanced traffic
    task automatic test_mixed_traffic();
        for (int k = 0; k < NUM_TIMERS; k++) begin
            staged_regs[REG_TIMER0_INTERVAL + k]  = CFG_W'($urandom_range(1, 4));
            staged_regs[REG_TIMER0_LISTENERS + k] = CFG_W'($urandom);
        end
        staged_regs[REG_IDLE_LISTENERS]  = CFG_W'($urandom);
        staged_regs[REG_START_LISTENERS] = CFG_W'($urandom);
        load_config();
        run_mix(400, 40, 35, 15);
    endtask

    // Tick-heavy traffic so timers expire often and refill the queue
    task automatic test_tick_storm();
        staged_regs[REG_TIMER0_INTERVAL] = 16'd2;
        staged_regs[REG_TIMER1_INTERVAL] = 16'd3;
        staged_regs[REG_TIMER2_INTERVAL] = 16'd5;
        for (int k = 0; k < NUM_TIMERS; k++)
            staged_regs[REG_TIMER0_LISTENERS + k] = CFG_W'($urandom);
        staged_regs[REG_IDLE_LISTENERS]  = 16'h0000;
        staged_regs[REG_START_LISTENERS] = CFG_W'($urandom);
        load_config();
        run_mix(300, 10, 40, 45);
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_back_pressure();
        gaps_on = 1'b0;
        holds_wanted++;
        run_mix(40, 40, 30, 20);
        settle();
        gaps_on = 1'b1;
    endtask

    // Largest interval, interval one, a disabled timer and a full listener mask
    task automatic test_timer_extremes();
        staged_regs[REG_TIMER0_INTERVAL]  = 16'hFFFF;
        staged_regs[REG_TIMER1_INTERVAL]  = 16'd1;
        staged_regs[REG_TIMER2_INTERVAL]  = 16'd0;
        staged_regs[REG_TIMER0_LISTENERS] = 16'hFFFF;
        staged_regs[REG_TIMER1_LISTENERS] = 16'h0001;
        staged_regs[REG_TIMER2_LISTENERS] = 16'hAAAA;
        staged_regs[REG_IDLE_LISTENERS]   = 16'h5555;
        staged_regs[REG_START_LISTENERS]  = 16'h0000;
        load_config();
        run_mix(300, 25, 50, 20);
    endtask

    // Every register loaded with a full-width random value
    task automatic test_random_registers();
        for (int r = 0; r < NUM_REGS; r++) staged_regs[r] = CFG_W'($urandom);
        load_config();
        run_mix(300, 30, 30, 30);
    endtask

    // Back-to-back beats with no idling on either side
    task automatic test_streaming();
        for (int k = 0; k < NUM_TIMERS; k++) begin
            staged_regs[REG_TIMER0_INTERVAL + k]  = CFG_W'($urandom_range(1, 3));
            staged_regs[REG_TIMER0_LISTENERS + k] = CFG_W'($urandom);
        end
        staged_regs[REG_IDLE_LISTENERS]  = CFG_W'($urandom);
        staged_regs[REG_START_LISTENERS] = CFG_W'($urandom);
        load_config();
        gaps_on = 1'b0;
        run_mix(535, 35, 35, 20);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_queue();
        test_listener_sets();
        test_mixed_traffic();
        test_tick_storm();
        test_back_pressure();
        test_timer_extremes();
        test_random_registers();
        test_streaming();
        // every predicted beat is in; stray beats in the quiet tail still count
        settle();
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/tdrq_pkg.sv
design/tdrq_front.sv
design/tdrq_cmd_fifo.sv
design/tdrq_back.sv
design/timer_driven_run_queue_unit.sv
sim/tb.sv
